[src/fhcf_pkg.sv]
`default_nettype none
package fhcf_pkg;

    localparam int TAPS    = 256;
    localparam int SMP_W   = 24;
    localparam int IDX_W   = 8;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = $clog2(TAPS);
    localparam int MUL_W   = 2 * SMP_W;
    localparam int ACC_W   = MUL_W + CNT_W;
    localparam int Y_W     = ACC_W - 22;
    localparam int PROD_W  = Y_W + LEN_W + 2;
    localparam int NUM_W   = Y_W + LEN_W;
    localparam int PADDR_W = 3;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TAP    = 2'd1,
        FUNC_COMMIT = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ROUND,
        S_SETTLE,
        S_MUL,
        S_DIVST,
        S_DIVW,
        S_FIN,
        S_LOAD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic hist_move;
        logic bank_move;
        logic clear_hist;
        logic load_target;
        logic load_active;
    } t_cell_ctrl;

    function automatic logic signed [Y_W-1:0] round_q23(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W:0] v;
        v = (ACC_W + 1)'(s) + (ACC_W + 1)'(1 << 22);
        return $signed(v[ACC_W:23]);
    endfunction

endpackage
`default_nettype wire

[src/fhcf_cell.sv]
`default_nettype none
module fhcf_cell (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  fhcf_pkg::t_cell_ctrl               i_ctrl,
    input  wire                                i_pend_we,
    input  wire signed [fhcf_pkg::SMP_W-1:0]   i_pend_val,
    input  wire signed [fhcf_pkg::SMP_W-1:0]   i_hist,
    input  wire signed [fhcf_pkg::SMP_W-1:0]   i_act,
    input  wire signed [fhcf_pkg::SMP_W-1:0]   i_tgt,
    output logic signed [fhcf_pkg::SMP_W-1:0]  o_hist,
    output logic signed [fhcf_pkg::SMP_W-1:0]  o_act,
    output logic signed [fhcf_pkg::SMP_W-1:0]  o_tgt
);

    logic signed [fhcf_pkg::SMP_W-1:0] r_hist;
    logic signed [fhcf_pkg::SMP_W-1:0] r_act;
    logic signed [fhcf_pkg::SMP_W-1:0] r_tgt;
    logic signed [fhcf_pkg::SMP_W-1:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_act  <= '0;
            r_tgt  <= '0;
        end else begin
            if (i_ctrl.clear_hist) begin
                r_hist <= '0;
            end else if (i_ctrl.hist_move || i_ctrl.bank_move) begin
                r_hist <= i_hist;
            end
            if (i_ctrl.bank_move) begin
                r_act <= i_act;
                r_tgt <= i_tgt;
            end else begin
                if (i_ctrl.load_target) begin
                    r_tgt <= r_pend;
                end
                if (i_ctrl.load_active) begin
                    r_act <= i_ctrl.load_target ? r_pend : r_tgt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pend_we) begin
            r_pend <= i_pend_val;
        end
    end

    assign o_hist = r_hist;
    assign o_act  = r_act;
    assign o_tgt  = r_tgt;

endmodule
`default_nettype wire

[src/fhcf_div.sv]
`default_nettype none
module fhcf_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire [fhcf_pkg::NUM_W-1:0]        i_num,
    input  wire [fhcf_pkg::LEN_W-1:0]        i_den,
    output logic                             o_done,
    output logic [fhcf_pkg::NUM_W-1:0]       o_quo
);

    localparam int DC_W = $clog2(fhcf_pkg::NUM_W);

    logic                          r_busy;
    logic                          r_done;
    logic [DC_W-1:0]               r_cnt;
    logic [fhcf_pkg::LEN_W-1:0]    r_rem;
    logic [fhcf_pkg::NUM_W-1:0]    r_quo;
    logic [fhcf_pkg::LEN_W-1:0]    r_den;
    logic [fhcf_pkg::LEN_W:0]      w_sh;
    logic                          w_ge;
    logic [fhcf_pkg::LEN_W:0]      w_rem;

    always_comb begin
        w_sh  = {r_rem, r_quo[fhcf_pkg::NUM_W-1]};
        w_ge  = w_sh >= {1'b0, r_den};
        w_rem = w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DC_W'(fhcf_pkg::NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= w_rem[fhcf_pkg::LEN_W-1:0];
            r_quo <= {r_quo[fhcf_pkg::NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

[src/fir_head_with_coefficient_crossfade.sv]
`default_nettype none
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_ready      func, sample_in, tail_in, tap_index,
//                                                    tap_value, discard_history
// output    out        o_out_valid / i_out_ready    sample_out, fading
// config    in         psel, penable, pwrite        paddr, pwdata, prdata (ramp_length)
//
// sample: the tap ring rotates once past the shared active and target macs, and while fading
// one serial divider forms the blend; input stays not ready until the result moves on
// commit: settles a running fade tap by tap through the divider, then loads; tap write: stays idle
// passthrough before the first commit: the sample goes straight to the output
// synchronous active-low reset clears history and both tap banks
// a finished result waits in a result register until the output register is free
module fir_head_with_coefficient_crossfade (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  wire [1:0]                              i_func,
    input  wire signed [fhcf_pkg::SMP_W-1:0]       i_sample_in,
    input  wire signed [fhcf_pkg::SMP_W-1:0]       i_tail_in,
    input  wire [fhcf_pkg::IDX_W-1:0]              i_tap_index,
    input  wire signed [fhcf_pkg::SMP_W-1:0]       i_tap_value,
    input  wire                                    i_discard_history,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output logic signed [fhcf_pkg::SMP_W-1:0]      o_sample_out,
    output logic                                   o_fading,
    input  wire                                    psel,
    input  wire                                    penable,
    input  wire                                    pwrite,
    input  wire [fhcf_pkg::PADDR_W-1:0]            paddr,
    input  wire [31:0]                             pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int TAPS  = fhcf_pkg::TAPS;
    localparam int SMP_W = fhcf_pkg::SMP_W;
    localparam int Y_W   = fhcf_pkg::Y_W;
    localparam int LEN_W = fhcf_pkg::LEN_W;

    fhcf_pkg::t_state                     r_state;
    fhcf_pkg::t_state                     n_state;
    fhcf_pkg::t_cell_ctrl                 w_ctrl;
    fhcf_pkg::t_func                      w_func;

    logic                                 w_acc_in;
    logic                                 w_div_start;
    logic                                 w_div_done;
    logic [fhcf_pkg::NUM_W-1:0]           w_div_quo;
    logic [fhcf_pkg::NUM_W-1:0]           w_div_num;
    logic signed [fhcf_pkg::PROD_W-1:0]   w_pmag;

    logic [fhcf_pkg::CNT_W-1:0]           r_cnt;
    logic signed [fhcf_pkg::ACC_W-1:0]    r_acc_a;
    logic signed [fhcf_pkg::ACC_W-1:0]    r_acc_t;
    logic signed [fhcf_pkg::MUL_W-1:0]    r_pa;
    logic signed [fhcf_pkg::MUL_W-1:0]    r_pt;
    logic                                 r_pv;
    logic signed [Y_W-1:0]                r_ba;
    logic signed [Y_W-1:0]                r_bt;
    logic signed [fhcf_pkg::PROD_W-1:0]   r_prod;
    logic                                 r_neg;
    logic signed [Y_W:0]                  r_q;
    logic [LEN_W-1:0]                     r_fade;
    logic                                 r_applied;
    logic [LEN_W-1:0]                     r_ramp;
    logic                                 r_settle;
    logic signed [SMP_W-1:0]              r_tail;
    logic signed [SMP_W-1:0]              r_res_smp;
    logic                                 r_res_fad;
    logic                                 r_ov;
    logic signed [SMP_W-1:0]              r_out_smp;
    logic                                 r_out_fad;

    logic [LEN_W-1:0]                     w_len;
    logic [LEN_W-1:0]                     w_left;
    logic [LEN_W-1:0]                     w_wt;
    logic signed [Y_W+1:0]                w_sum;
    logic signed [Y_W+1:0]                w_y;
    logic signed [SMP_W-1:0]              w_sat;
    logic                                 w_out_free;

    logic signed [SMP_W-1:0]              w_hist [TAPS];
    logic signed [SMP_W-1:0]              w_act  [TAPS];
    logic signed [SMP_W-1:0]              w_tgt  [TAPS];
    logic signed [SMP_W-1:0]              w_hin;
    logic signed [SMP_W-1:0]              w_ain;

    assign w_func     = fhcf_pkg::t_func'(i_func);
    assign o_in_ready = (r_state == fhcf_pkg::S_IDLE);
    assign w_acc_in   = i_in_valid && o_in_ready;
    assign w_out_free = !r_ov || i_out_ready;

    // tap cell ring
    assign w_hin = (r_state == fhcf_pkg::S_IDLE) ? i_sample_in : w_hist[TAPS-1];
    assign w_ain = (r_state == fhcf_pkg::S_FIN) ? w_sum[SMP_W-1:0] : w_act[TAPS-1];

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        fhcf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_pend_we  (w_acc_in && w_func == fhcf_pkg::FUNC_TAP &&
                         32'(i_tap_index) == k),
            .i_pend_val (i_tap_value),
            .i_hist     ((k == 0) ? w_hin : w_hist[(k == 0) ? 0 : k-1]),
            .i_act      ((k == 0) ? w_ain : w_act[(k == 0) ? 0 : k-1]),
            .i_tgt      ((k == 0) ? w_tgt[TAPS-1] : w_tgt[(k == 0) ? 0 : k-1]),
            .o_hist     (w_hist[k]),
            .o_act      (w_act[k]),
            .o_tgt      (w_tgt[k])
        );
    end

    // blend weight, divider operand, tail sum and saturation
    always_comb begin
        w_len  = (r_ramp == '0) ? LEN_W'(1) : r_ramp;
        w_left = (r_fade > w_len) ? w_len : r_fade;
        w_wt   = w_len - w_left;
        w_pmag = r_prod[fhcf_pkg::PROD_W-1] ? -r_prod : r_prod;
        w_div_num = w_pmag[fhcf_pkg::NUM_W-1:0];
        w_sum  = (Y_W + 2)'(r_ba) + (Y_W + 2)'(r_q);
        w_y    = w_sum + (Y_W + 2)'(r_tail);
        if (w_y > $signed((Y_W + 2)'(8388607))) begin
            w_sat = SMP_W'(8388607);
        end else if (w_y < -$signed((Y_W + 2)'(8388608))) begin
            w_sat = -SMP_W'(8388608);
        end else begin
            w_sat = w_y[SMP_W-1:0];
        end
    end

    fhcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_len),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fhcf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_ctrl      = '0;
        w_div_start = 1'b0;
        case (r_state)
            fhcf_pkg::S_IDLE: begin
                if (w_acc_in) begin
                    case (w_func)
                        fhcf_pkg::FUNC_SAMPLE: begin
                            if (r_applied) begin
                                w_ctrl.hist_move = 1'b1;
                                n_state = fhcf_pkg::S_MAC;
                            end else begin
                                n_state = fhcf_pkg::S_OUT;
                            end
                        end
                        fhcf_pkg::FUNC_COMMIT: begin
                            w_ctrl.clear_hist = i_discard_history;
                            n_state = (r_fade != '0) ? fhcf_pkg::S_SETTLE : fhcf_pkg::S_LOAD;
                        end
                        default: ;
                    endcase
                end
            end
            fhcf_pkg::S_MAC: begin
                w_ctrl.bank_move = 1'b1;
                if (r_cnt == fhcf_pkg::CNT_W'(TAPS - 1)) begin
                    n_state = fhcf_pkg::S_DRAIN;
                end
            end
            fhcf_pkg::S_DRAIN:  n_state = fhcf_pkg::S_ROUND;
            fhcf_pkg::S_ROUND:  n_state = (r_fade != '0) ? fhcf_pkg::S_MUL : fhcf_pkg::S_FIN;
            fhcf_pkg::S_SETTLE: n_state = fhcf_pkg::S_MUL;
            fhcf_pkg::S_MUL:    n_state = fhcf_pkg::S_DIVST;
            fhcf_pkg::S_DIVST: begin
                w_div_start = 1'b1;
                n_state = fhcf_pkg::S_DIVW;
            end
            fhcf_pkg::S_DIVW: begin
                if (w_div_done) begin
                    n_state = fhcf_pkg::S_FIN;
                end
            end
            fhcf_pkg::S_FIN: begin
                if (r_settle) begin
                    w_ctrl.bank_move = 1'b1;
                    n_state = (r_cnt == fhcf_pkg::CNT_W'(TAPS - 1)) ?
                              fhcf_pkg::S_LOAD : fhcf_pkg::S_SETTLE;
                end else begin
                    w_ctrl.load_active = (r_fade == LEN_W'(1));
                    n_state = fhcf_pkg::S_OUT;
                end
            end
            fhcf_pkg::S_LOAD: begin
                w_ctrl.load_target = 1'b1;
                w_ctrl.load_active = !r_applied;
                n_state = fhcf_pkg::S_IDLE;
            end
            fhcf_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = fhcf_pkg::S_IDLE;
                end
            end
            default: n_state = fhcf_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade    <= '0;
            r_applied <= 1'b0;
            r_ramp    <= LEN_W'(2048);
            r_ov      <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            if (psel && penable && pwrite && !paddr[2]) begin
                r_ramp <= pwdata[LEN_W-1:0];
            end
            if (r_state == fhcf_pkg::S_MAC) begin
                r_pv <= 1'b1;
            end else begin
                r_pv <= 1'b0;
            end
            if (r_state == fhcf_pkg::S_FIN) begin
                if (r_settle) begin
                    if (r_cnt == fhcf_pkg::CNT_W'(TAPS - 1)) begin
                        r_fade <= '0;
                    end
                end else if (r_fade != '0) begin
                    r_fade <= r_fade - 1'b1;
                end
            end
            if (r_state == fhcf_pkg::S_LOAD) begin
                r_applied <= 1'b1;
                r_fade    <= r_applied ? w_len : '0;
            end
            if (r_state == fhcf_pkg::S_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_cnt     <= '0;
            r_acc_a   <= '0;
            r_acc_t   <= '0;
            r_tail    <= i_tail_in;
            r_settle  <= (w_func == fhcf_pkg::FUNC_COMMIT);
            r_res_smp <= i_sample_in;
            r_res_fad <= 1'b0;
        end
        case (r_state)
            fhcf_pkg::S_MAC: begin
                r_cnt <= r_cnt + 1'b1;
                r_pa  <= w_act[TAPS-1] * w_hist[TAPS-1];
                r_pt  <= w_tgt[TAPS-1] * w_hist[TAPS-1];
                if (r_pv) begin
                    r_acc_a <= r_acc_a + fhcf_pkg::ACC_W'(r_pa);
                    r_acc_t <= r_acc_t + fhcf_pkg::ACC_W'(r_pt);
                end
            end
            fhcf_pkg::S_DRAIN: begin
                r_cnt   <= '0;
                r_acc_a <= r_acc_a + fhcf_pkg::ACC_W'(r_pa);
                r_acc_t <= r_acc_t + fhcf_pkg::ACC_W'(r_pt);
            end
            fhcf_pkg::S_ROUND: begin
                r_ba <= fhcf_pkg::round_q23(r_acc_a);
                r_bt <= fhcf_pkg::round_q23(r_acc_t);
                r_q  <= '0;
            end
            fhcf_pkg::S_SETTLE: begin
                r_ba <= Y_W'(w_act[TAPS-1]);
                r_bt <= Y_W'(w_tgt[TAPS-1]);
            end
            fhcf_pkg::S_MUL: begin
                r_prod <= (fhcf_pkg::PROD_W'(r_bt) - fhcf_pkg::PROD_W'(r_ba)) *
                          $signed({1'b0, w_wt});
            end
            fhcf_pkg::S_DIVST: begin
                r_neg <= r_prod[fhcf_pkg::PROD_W-1];
            end
            fhcf_pkg::S_DIVW: begin
                if (w_div_done) begin
                    r_q <= r_neg ? -$signed({1'b0, w_div_quo[Y_W-1:0]}) :
                                    $signed({1'b0, w_div_quo[Y_W-1:0]});
                end
            end
            fhcf_pkg::S_FIN: begin
                if (r_settle) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_res_smp <= w_sat;
                    r_res_fad <= (r_fade != '0);
                end
            end
            default: ;
        endcase
        if (r_state == fhcf_pkg::S_OUT && w_out_free) begin
            r_out_smp <= r_res_smp;
            r_out_fad <= r_res_fad;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_sample_out = r_out_smp;
    assign o_fading     = r_out_fad;
    assign prdata       = paddr[2] ? 32'd0 : {16'd0, r_ramp};
    assign pready       = 1'b1;

endmodule
`default_nettype wire

[src/fhcf_checker.sv]
`default_nettype none
module fhcf_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               o_in_ready,
    input wire [1:0]                         i_func,
    input wire                               o_out_valid,
    input wire                               i_out_ready,
    input wire [fhcf_pkg::SMP_W-1:0]         o_sample_out,
    input wire                               pready
);

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output changed");

    a_tap_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid && i_func == fhcf_pkg::FUNC_TAP
        |=> !o_out_valid)
        else $error("tap write produced a result");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_func == fhcf_pkg::FUNC_SAMPLE |=> !o_in_ready)
        else $error("sample transaction did not occupy the block");

endmodule

bind fir_head_with_coefficient_crossfade fhcf_checker u_fhcf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_func       (i_func),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out),
    .pready       (pready)
);
`default_nettype wire

[bench/fir_head_with_coefficient_crossfade_tb.sv]
`default_nettype none
module fir_head_with_coefficient_crossfade_tb;

    typedef struct {
        fhcf_pkg::t_func func;
        logic [23:0] smp;
        logic [23:0] tail;
        logic [7:0]  idx;
        logic [23:0] tval;
        logic        discard;
    } t_txn;

    typedef struct {
        logic [23:0] smp;
        logic        fading;
    } t_res;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic [1:0] i_func = 0;
    logic [23:0] i_sample_in = 0, i_tail_in = 0, i_tap_value = 0;
    logic [7:0] i_tap_index = 0;
    logic i_discard_history = 0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic signed [23:0] o_sample_out;
    logic o_fading;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [fhcf_pkg::PADDR_W-1:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    fir_head_with_coefficient_crossfade dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // predictor state
    logic signed [23:0] hist [fhcf_pkg::TAPS];
    logic signed [23:0] act_bank [fhcf_pkg::TAPS];
    logic signed [23:0] tgt_bank [fhcf_pkg::TAPS];
    logic signed [23:0] pend_bank [fhcf_pkg::TAPS];
    int unsigned hpos, fade_cnt, ramp;
    bit applied;

    t_txn pending_q[$];
    t_res expected_q[$];
    int errors = 0, n_samples = 0, n_faded = 0, n_commits = 0;
    int gap_cnt = 0, hold_cnt = 0, long_hold = 0;
    bit drain_busy = 0;

    function automatic longint bank_acc(bit use_target);
        longint acc = 0;
        int unsigned p = hpos;
        for (int j = 0; j < fhcf_pkg::TAPS; j++) begin
            acc += longint'(use_target ? tgt_bank[j] : act_bank[j]) * longint'(hist[p]);
            p = (p == 0) ? fhcf_pkg::TAPS - 1 : p - 1;
        end
        return acc;
    endfunction

    function automatic longint to_q23(longint s);
        return (s + (64'sd1 <<< 22)) >>> 23;
    endfunction

    function automatic longint eff_left(output longint len);
        longint l;
        len = (ramp == 0) ? 1 : ramp;
        l = fade_cnt;
        return (l > len) ? len : l;
    endfunction

    function automatic void predict(t_txn t);
        longint y, tg, len, left;
        t_res r;
        case (t.func)
            fhcf_pkg::FUNC_TAP: pend_bank[t.idx] = t.tval;
            fhcf_pkg::FUNC_COMMIT: begin
                n_commits++;
                if (t.discard) foreach (hist[i]) hist[i] = 0;
                if (fade_cnt != 0) begin
                    left = eff_left(len);
                    foreach (act_bank[i])
                        act_bank[i] = 24'(longint'(act_bank[i]) +
                            ((longint'(tgt_bank[i]) - longint'(act_bank[i])) * (len - left))
                            / len);
                    fade_cnt = 0;
                end
                tgt_bank = pend_bank;
                if (applied) fade_cnt = (ramp == 0) ? 1 : ramp;
                else begin
                    act_bank = tgt_bank;
                    applied = 1;
                end
            end
            fhcf_pkg::FUNC_SAMPLE: begin
                n_samples++;
                if (!applied) begin
                    r.smp = t.smp;
                    r.fading = 0;
                end else begin
                    hist[hpos] = t.smp;
                    y = to_q23(bank_acc(0));
                    r.fading = 0;
                    if (fade_cnt > 0) begin
                        left = eff_left(len);
                        tg = to_q23(bank_acc(1));
                        y = y + ((tg - y) * (len - left)) / len;
                        r.fading = 1;
                        n_faded++;
                        fade_cnt--;
                        if (fade_cnt == 0) act_bank = tgt_bank;
                    end
                    y += longint'($signed(t.tail));
                    if (y > 8388607) y = 8388607;
                    if (y < -8388608) y = -8388608;
                    hpos = (hpos + 1) % fhcf_pkg::TAPS;
                    r.smp = y[23:0];
                end
                expected_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict('{fhcf_pkg::t_func'(i_func), i_sample_in, i_tail_in,
                          i_tap_index, i_tap_value, i_discard_history});
            if (!i_in_valid || o_in_ready) begin
                if (gap_cnt > 0 || pending_q.size() == 0) begin
                    i_in_valid <= 0;
                    if (gap_cnt > 0) gap_cnt <= gap_cnt - 1;
                end else begin
                    t_txn t;
                    t = pending_q.pop_front();
                    i_in_valid <= 1;
                    i_func <= t.func;
                    i_sample_in <= t.smp;
                    i_tail_in <= t.tail;
                    i_tap_index <= t.idx;
                    i_tap_value <= t.tval;
                    i_discard_history <= t.discard;
                    gap_cnt <= ($urandom_range(0, 3) != 0) ? 0 :
                               ($urandom_range(0, 9) == 0 ? $urandom_range(20, 300)
                                                          : $urandom_range(1, 4));
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result sample_out=%h fading=%b",
                             $time, o_sample_out, o_fading);
                    errors++;
                end else begin
                    t_res e;
                    e = expected_q.pop_front();
                    if (e.smp !== o_sample_out) begin
                        $display("%0t: sample_out expected %h actual %h", $time, e.smp,
                                 o_sample_out);
                        errors++;
                    end
                    if (e.fading !== o_fading) begin
                        $display("%0t: fading expected %b actual %b", $time, e.fading,
                                 o_fading);
                        errors++;
                    end
                end
            end
            if (long_hold > 0) begin
                i_out_ready <= 0;
                long_hold <= long_hold - 1;
            end else if (hold_cnt > 0) begin
                i_out_ready <= 0;
                hold_cnt <= hold_cnt - 1;
            end else if (drain_busy || $urandom_range(0, 3) != 0) begin
                i_out_ready <= 1;
            end else begin
                i_out_ready <= 0;
                hold_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 1500)
                                                       : $urandom_range(1, 5);
            end
        end
    end

    function automatic logic [23:0] rnd24();
        case ($urandom_range(0, 5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hffffff;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic t_txn mk(fhcf_pkg::t_func f, logic [23:0] s, logic [7:0] ix,
                                logic [23:0] v, logic d);
        t_txn t;
        t.func = f;
        t.smp = s;
        t.tail = rnd24();
        t.idx = ix;
        t.tval = v;
        t.discard = d;
        return t;
    endfunction

    function automatic void push_taps(int ntaps, bit small_vals);
        for (int k = 0; k < ntaps; k++) begin
            logic [23:0] v;
            v = small_vals ? 24'($signed($urandom_range(0, 200000)) - 100000) : rnd24();
            pending_q.push_back(mk(fhcf_pkg::FUNC_TAP, 0, k[7:0], v, 0));
        end
    endfunction

    task automatic wait_idle();
        int cnt;
        while (pending_q.size() != 0 || i_in_valid || expected_q.size() != 0)
            @(posedge i_clk);
        cnt = 0;
        drain_busy = 1;
        while (cnt < fhcf_pkg::TAPS * (fhcf_pkg::NUM_W + 6) + 100) begin
            @(posedge i_clk);
            cnt++;
        end
        drain_busy = 0;
    endtask

    task automatic write_ramp(logic [15:0] v);
        @(posedge i_clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= 0;
        pwdata <= {16'h0, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        ramp = v;
    endtask

    initial begin
        foreach (hist[i]) begin
            hist[i] = 0;
            act_bank[i] = 0;
            tgt_bank[i] = 0;
            pend_bank[i] = 0;
        end
        hpos = 0;
        fade_cnt = 0;
        ramp = 2048;
        applied = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: passthrough, unknown func, first commit, fades, extremes
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h7fffff, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h800000, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_NONE, 24'h123456, 8'hff, 24'hffffff, 1));
        push_taps(fhcf_pkg::TAPS, 0);
        wait_idle();
        write_ramp(3);
        pending_q.push_back(mk(fhcf_pkg::FUNC_COMMIT, 0, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h7fffff, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h800000, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_TAP, 0, 8'hff, 24'h7fffff, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_TAP, 0, 8'h00, 24'h800000, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_COMMIT, 0, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h7fffff, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_COMMIT, 0, 0, 0, 1));
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h800000, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h000001, 0, 0, 0));
        wait_idle();
        write_ramp(0);
        pending_q.push_back(mk(fhcf_pkg::FUNC_COMMIT, 0, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h400000, 0, 0, 0));
        wait_idle();
        write_ramp(16'hffff);
        pending_q.push_back(mk(fhcf_pkg::FUNC_COMMIT, 0, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h7fffff, 0, 0, 0));
        wait_idle();
        // lowering the length mid-fade leaves the count above it
        write_ramp(1);
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h800000, 0, 0, 0));
        pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, 24'h7fffff, 0, 0, 0));
        wait_idle();

        // random phases
        for (int ph = 0; ph < 4; ph++) begin
            write_ramp(ph == 3 ? 16'd2 : 16'($urandom_range(1, 40)));
            for (int k = 0; k < 185; k++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 80)
                    pending_q.push_back(mk(fhcf_pkg::FUNC_SAMPLE, rnd24(), 0, 0, 0));
                else if (r < 95)
                    pending_q.push_back(mk(fhcf_pkg::FUNC_TAP, 0, 8'($urandom()),
                                           ($urandom_range(0, 1) ? rnd24()
                                            : 24'($signed($urandom_range(0, 20000)) - 10000)),
                                           $urandom_range(0, 1)));
                else if (r < 98)
                    pending_q.push_back(mk(fhcf_pkg::FUNC_COMMIT, 0, 0, 0,
                                           $urandom_range(0, 1)));
                else
                    pending_q.push_back(mk(fhcf_pkg::FUNC_NONE, rnd24(), 8'($urandom()),
                                           rnd24(), $urandom_range(0, 1)));
            end
            if (ph == 1) long_hold = 6000;
            wait_idle();
        end

        $display("covered %0d samples (%0d during crossfades) and %0d commits", n_samples,
                 n_faded, n_commits);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #200000000;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
